// ----- design/bufu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffered UART FIFO controller package
// Shared constants, event codes and status types for the UART FIFO block.
// ----------------------------------------------------------------------------
package bufu_pkg;

    // Ring depth; one slot stays empty, so a ring holds QUEUE_DEPTH-1 bytes
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [7:0]       byte_t;
    typedef logic [PTR_W-1:0] ptr_t;

    // Event codes carried on the event channel
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_TX_DONE = 2'd2,
        KIND_RX_BYTE = 2'd3
    } kind_t;

    // Status of one ring as seen by the controller
    typedef struct packed {
        logic  empty;
        logic  full;
        byte_t pop_data;
    } ring_stat_t;

endpackage

// ----- design/bufu_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffered UART FIFO channel interfaces
// Valid/ready channels for host and shifter events and for step results.
// ----------------------------------------------------------------------------
interface bufu_evt_if;
    import bufu_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    byte_t data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface bufu_res_if;
    import bufu_pkg::*;

    logic  valid;
    logic  ready;
    logic  write_accepted;
    byte_t read_byte;
    logic  read_valid;
    logic  tx_start;
    byte_t tx_byte;
    logic  busy_sending;

    modport source (output valid, output write_accepted, output read_byte,
                    output read_valid, output tx_start, output tx_byte,
                    output busy_sending, input ready);
    modport sink   (input valid, input write_accepted, input read_byte,
                    input read_valid, input tx_start, input tx_byte,
                    input busy_sending, output ready);
endinterface

// ----- design/bufu_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO
// Circular byte store with read and write pointers, one slot kept empty.
// A pop from an empty ring in the same cycle as a push returns the pushed byte.
// ----------------------------------------------------------------------------
module bufu_ring (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bufu_pkg::byte_t      push_data,
    input  logic                 pop,
    output bufu_pkg::ring_stat_t stat
);
    import bufu_pkg::*;

    byte_t store [QUEUE_DEPTH];
    ptr_t  rd_ptr_reg;
    ptr_t  rd_ptr_next;
    ptr_t  wr_ptr_reg;
    ptr_t  wr_ptr_next;
    ptr_t  wr_ptr_inc;
    ptr_t  rd_ptr_inc;
    logic  empty;
    logic  pop_taken;

    // Advance a pointer with wrap at the last slot
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // Derive status and forward the pushed byte when the ring is empty
    always_comb
    begin
        wr_ptr_inc     = ptr_inc(wr_ptr_reg);
        rd_ptr_inc     = ptr_inc(rd_ptr_reg);
        empty          = (rd_ptr_reg == wr_ptr_reg);
        stat.empty     = empty;
        stat.full      = (wr_ptr_inc == rd_ptr_reg);
        pop_taken      = pop && (!empty || push);
        if (!empty)
        begin
            stat.pop_data = store[rd_ptr_reg];
        end
        else if (push)
        begin
            stat.pop_data = push_data;
        end
        else
        begin
            stat.pop_data = '0;
        end
        wr_ptr_next = push      ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = pop_taken ? rd_ptr_inc : rd_ptr_reg;
    end

    // Hold the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Write the pushed byte into its slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/buffered_uart_fifo_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffered UART FIFO controller
// Transmit and receive byte rings between a host and a serial shifter.
//
// Usage:
//   evt carries one event per transaction: host write (byte queued for
//   transmission), host read, transmitter done, or byte received.
//   res returns exactly one result transaction per event: write acceptance,
//   the byte read and its valid flag, a start strobe with the byte handed to
//   the shifter, and the sending flag after the event.
//   res becomes valid in the cycle after evt acceptance. One event is
//   taken every cycle while res is drained; the single result register
//   decides the rate, and the rings are updated in the accepting cycle so
//   the next event sees the new state.
//   When res stalls, the result register holds and evt.ready drops until
//   the result is taken.
//   Reset empties both rings (pointers to zero) and clears the sending flag;
//   ring contents are not cleared.
// ----------------------------------------------------------------------------
module buffered_uart_fifo_controller (
    input  logic      clk,
    input  logic      rst_n,
    bufu_evt_if.sink  evt,
    bufu_res_if.source res
);
    import bufu_pkg::*;

    ring_stat_t tx_stat;
    ring_stat_t rx_stat;
    logic       accept;
    logic       tx_push;
    logic       tx_pop;
    logic       rx_push;
    logic       rx_pop;
    logic       start_now;

    logic       res_valid_reg;
    logic       res_valid_next;
    logic       sending_reg;
    logic       sending_next;
    logic       write_accepted_reg;
    logic       write_accepted_next;
    byte_t      read_byte_reg;
    byte_t      read_byte_next;
    logic       read_valid_reg;
    logic       read_valid_next;
    logic       tx_start_reg;
    byte_t      tx_byte_reg;
    byte_t      tx_byte_next;

    // Take a new transaction whenever the result register is free or drains
    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    // Decode the event against ring status
    always_comb
    begin
        tx_push = 1'b0;
        tx_pop  = 1'b0;
        rx_push = 1'b0;
        rx_pop  = 1'b0;
        if (accept)
        begin
            case (evt.kind)
                KIND_WRITE:
                begin
                    tx_push = !tx_stat.full;
                    tx_pop  = !tx_stat.full && !sending_reg;
                end
                KIND_READ:    rx_pop  = 1'b1;
                KIND_TX_DONE: tx_pop  = 1'b1;
                KIND_RX_BYTE: rx_push = !rx_stat.full;
                default:
                begin
                    tx_push = 1'b0;
                end
            endcase
        end

        // A popped zero byte ends the transmit cycle
        start_now    = tx_pop && (tx_stat.pop_data != '0);
        sending_next = tx_pop ? start_now : sending_reg;

        write_accepted_next = tx_push;
        read_valid_next     = rx_pop && !rx_stat.empty;
        read_byte_next      = read_valid_next ? rx_stat.pop_data : '0;
        tx_byte_next        = start_now ? tx_stat.pop_data : '0;
        res_valid_next      = accept || (res_valid_reg && !res.ready);
    end

    bufu_ring u_tx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tx_push),
        .push_data (evt.data_byte),
        .pop       (tx_pop),
        .stat      (tx_stat)
    );

    bufu_ring u_rx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rx_push),
        .push_data (evt.data_byte),
        .pop       (rx_pop),
        .stat      (rx_stat)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sending_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            sending_reg   <= sending_next;
        end
    end

    // Load the result payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            write_accepted_reg <= write_accepted_next;
            read_byte_reg      <= read_byte_next;
            read_valid_reg     <= read_valid_next;
            tx_start_reg       <= start_now;
            tx_byte_reg        <= tx_byte_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.write_accepted = write_accepted_reg;
    assign res.read_byte      = read_byte_reg;
    assign res.read_valid     = read_valid_reg;
    assign res.tx_start       = tx_start_reg;
    assign res.tx_byte        = tx_byte_reg;
    assign res.busy_sending   = sending_reg;

endmodule
